### src/mesh_height_tracker_assert.svh
// assertion helpers for the mesh height tracker
`ifndef MESH_HEIGHT_TRACKER_ASSERT_SVH
`define MESH_HEIGHT_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mht_pkg.sv
package mht_pkg;

	// field and datapath widths
	localparam int CW   = 20;
	localparam int DW   = 21;
	localparam int MW   = 23;
	localparam int PW   = 2 * MW;
	localparam int ACCW = 66;
	localparam int WW   = 43;
	localparam int QW   = 21;
	localparam int HW   = 23;
	localparam int LOW_W = 22;
	localparam int CORNERS = 3;

	localparam logic [1:0] REQ_VERTEX    = 2'd0;
	localparam logic [1:0] REQ_NEIGHBOUR = 2'd1;
	localparam logic [1:0] REQ_QUERY     = 2'd2;

	localparam logic signed [CW-1:0] OFFSET_RESET = 20'sd205;
	localparam logic signed [HW-1:0] Q_MAX = 23'sd524287;
	localparam logic signed [HW-1:0] Q_MIN = -23'sd524288;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VRD,
		ST_BARY,
		ST_NORM,
		ST_EVAL,
		ST_HGT,
		ST_DIV,
		ST_NRD,
		ST_NCHK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic sub;
		logic hi;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vtx_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] idx;
	} nbr_t;

endpackage

### src/mht_ifs.sv
interface mht_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [7:0]          tri_index;
	logic [1:0]          slot;
	logic signed [19:0]  coord_x;
	logic signed [19:0]  coord_y;
	logic signed [19:0]  coord_z;
	logic [7:0]          neighbour_index;
	logic                neighbour_valid;

	modport source(output valid, req_type, tri_index, slot, coord_x, coord_y, coord_z,
		neighbour_index, neighbour_valid, input ready);
	modport sink(input valid, req_type, tri_index, slot, coord_x, coord_y, coord_z,
		neighbour_index, neighbour_valid, output ready);
endinterface

interface mht_resp_if;
	logic               valid;
	logic               ready;
	logic               height_valid;
	logic signed [19:0] height;
	logic [7:0]         current_index;

	modport source(output valid, height_valid, height, current_index, input ready);
	modport sink(input valid, height_valid, height, current_index, output ready);
endinterface

interface mht_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

### src/mesh_height_tracker.sv
// Triangle-mesh height tracker. Load beats (vertex corner, neighbour slot) are written to the stores
// when accepted. A query beat tests the point against the current triangle with barycentric
// weights and, if inside, returns the interpolated height plus height_offset; otherwise it walks
// to the first valid neighbour that holds the point and returns no height. Each triangle test
// runs three corner reads, eight products through the shared two-stage multiply-accumulate
// unit, sign normalization and evaluation; the walk adds a read per neighbour slot, and a hit on
// the current triangle adds four partial products and a 21-step radix-2 divider before the
// output register is loaded. The input is not ready while a query is in flight; a finished
// result waits in the output register without blocking the next beat. Stores are undefined
// until written.
module mesh_height_tracker #(
	parameter int MAX_TRIANGLES  = 256,
	parameter int MAX_NEIGHBOURS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	mht_req_if.sink    req,
	mht_resp_if.source resp,
	mht_cfg_if.sink    cfg
);
	import mht_pkg::*;

	localparam int DEPTH = MAX_TRIANGLES * CORNERS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic signed [MW-1:0] sx(input logic signed [DW-1:0] v);
		return {{(MW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	state_t state_q, state_d;

	vtx_t vmem [DEPTH];
	nbr_t nmem [DEPTH];
	vtx_t vrd_q;
	nbr_t nrd_q;

	logic signed [CW-1:0] offset_q;
	logic signed [CW-1:0] px_q, py_q;
	logic [7:0]           cur_q, tri_q;
	logic                 is_cur_q;
	logic [1:0]           nslot_q;
	logic [1:0]           rcnt_q;
	logic [3:0]           step_q;
	vtx_t                 crn_q [CORNERS];
	logic signed [WW-1:0] det_q, w0_q, w1_q, w2_q;
	logic                 res_hv_q;
	logic signed [CW-1:0] res_h_q;

	logic                 resp_valid_q;
	logic                 resp_hv_q;
	logic signed [CW-1:0] resp_h_q;
	logic [7:0]           resp_cur_q;

	logic                 acc_in;
	logic                 vwe, nwe, vre, nre, div_start;
	logic [31:0]          waddr_full, vraddr_full, nraddr_full;
	mac_ctrl_t            mctl;
	logic signed [MW-1:0] op_a, op_b;
	logic signed [ACCW-1:0] acc;
	div_stat_t            div_stat;
	logic signed [QW:0]   quot;
	logic                 hit;
	logic signed [HW-1:0] hsum;
	logic signed [CW-1:0] hsat;

	logic signed [DW-1:0] bax, bay, cax, cay;
	logic signed [DW-1:0] apx, apy, bpx, bpy, cpx, cpy;
	logic signed [DW-1:0] dzb, dzc;

	// arithmetic units (the multiply-accumulate unit is shared by the weight and height steps)
	mht_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	mht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc),
		.den    (det_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign acc_in    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// store writes
	assign waddr_full = 32'(req.tri_index) * 32'(CORNERS) + 32'(req.slot);
	assign vwe = acc_in && (req.req_type == REQ_VERTEX) &&
		(32'(req.tri_index) < 32'(MAX_TRIANGLES)) && (32'(req.slot) < 32'(CORNERS));
	assign nwe = acc_in && (req.req_type == REQ_NEIGHBOUR) &&
		(32'(req.tri_index) < 32'(MAX_TRIANGLES)) &&
		(32'(req.slot) < 32'(MAX_NEIGHBOURS)) && (32'(req.slot) < 32'(CORNERS));
	assign vraddr_full = 32'(tri_q) * 32'(CORNERS) + 32'(rcnt_q);
	assign nraddr_full = 32'(cur_q) * 32'(CORNERS) + 32'(nslot_q);

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[waddr_full[AW-1:0]] <= '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
		end
		if (vre) begin
			vrd_q <= vmem[vraddr_full[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (nwe) begin
			nmem[waddr_full[AW-1:0]] <= '{valid: req.neighbour_valid, idx: req.neighbour_index};
		end
		if (nre) begin
			nrd_q <= nmem[nraddr_full[AW-1:0]];
		end
	end

	// edge and point differences
	assign bax = dif(crn_q[1].x, crn_q[0].x);
	assign bay = dif(crn_q[1].y, crn_q[0].y);
	assign cax = dif(crn_q[2].x, crn_q[0].x);
	assign cay = dif(crn_q[2].y, crn_q[0].y);
	assign apx = dif(crn_q[0].x, px_q);
	assign apy = dif(crn_q[0].y, py_q);
	assign bpx = dif(crn_q[1].x, px_q);
	assign bpy = dif(crn_q[1].y, py_q);
	assign cpx = dif(crn_q[2].x, px_q);
	assign cpy = dif(crn_q[2].y, py_q);
	assign dzb = dif(crn_q[1].z, crn_q[0].z);
	assign dzc = dif(crn_q[2].z, crn_q[0].z);

	assign hit = (det_q != '0) && !w0_q[WW-1] && !w1_q[WW-1] && !w2_q[WW-1];

	// height plus offset, saturated
	assign hsum = {{(HW-CW){crn_q[0].z[CW-1]}}, crn_q[0].z} +
		{{(HW-QW-1){quot[QW]}}, quot} + {{(HW-CW){offset_q[CW-1]}}, offset_q};
	always_comb begin
		if (hsum > Q_MAX) begin
			hsat = CW'(Q_MAX);
		end else if (hsum < Q_MIN) begin
			hsat = CW'(Q_MIN);
		end else begin
			hsat = hsum[CW-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit control
	always_comb begin
		state_d   = state_q;
		mctl      = '0;
		op_a      = '0;
		op_b      = '0;
		vre       = 1'b0;
		nre       = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && (req.req_type == REQ_QUERY)) begin
					state_d = ST_VRD;
				end
			end
			ST_VRD: begin
				vre = (32'(rcnt_q) < 32'(CORNERS));
				if (32'(rcnt_q) == 32'(CORNERS)) begin
					state_d = ST_BARY;
				end
			end
			ST_BARY: begin
				if (step_q < 4'd8) begin
					mctl.en  = 1'b1;
					mctl.clr = !step_q[0];
					mctl.sub = step_q[0];
				end
				case (step_q[2:0])
					3'd0: begin op_a = sx(bax); op_b = sx(cay); end
					3'd1: begin op_a = sx(bay); op_b = sx(cax); end
					3'd2: begin op_a = sx(bpx); op_b = sx(cpy); end
					3'd3: begin op_a = sx(bpy); op_b = sx(cpx); end
					3'd4: begin op_a = sx(cpx); op_b = sx(apy); end
					3'd5: begin op_a = sx(cpy); op_b = sx(apx); end
					3'd6: begin op_a = sx(apx); op_b = sx(bpy); end
					3'd7: begin op_a = sx(apy); op_b = sx(bpx); end
					default: begin op_a = '0; op_b = '0; end
				endcase
				if (step_q == 4'd9) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (hit) begin
					state_d = is_cur_q ? ST_HGT : ST_OUT;
				end else begin
					state_d = ST_NRD;
				end
			end
			ST_HGT: begin
				if (step_q < 4'd4) begin
					mctl.en  = 1'b1;
					mctl.clr = (step_q == 4'd0);
					mctl.hi  = step_q[0];
				end
				case (step_q[1:0])
					2'd0: begin op_a = sx(dzb); op_b = MW'({1'b0, w1_q[LOW_W-1:0]}); end
					2'd1: begin op_a = sx(dzb); op_b = MW'({2'b00, w1_q[WW-1:LOW_W]}); end
					2'd2: begin op_a = sx(dzc); op_b = MW'({1'b0, w2_q[LOW_W-1:0]}); end
					2'd3: begin op_a = sx(dzc); op_b = MW'({2'b00, w2_q[WW-1:LOW_W]}); end
					default: begin op_a = '0; op_b = '0; end
				endcase
				if (step_q == 4'd5) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_NRD: begin
				if (32'(nslot_q) < 32'(MAX_NEIGHBOURS)) begin
					nre     = 1'b1;
					state_d = ST_NCHK;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_NCHK: begin
				if (nrd_q.valid && (32'(nrd_q.idx) < 32'(MAX_TRIANGLES))) begin
					state_d = ST_VRD;
				end else begin
					state_d = ST_NRD;
				end
			end
			ST_OUT: begin
				if (!resp_valid_q || resp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers: offset, current triangle, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			cur_q    <= '0;
			rcnt_q   <= '0;
			step_q   <= '0;
			nslot_q  <= '0;
			is_cur_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				offset_q <= cfg.data;
			end
			rcnt_q <= (state_q == ST_VRD) ? rcnt_q + 2'd1 : '0;
			step_q <= (state_q == ST_BARY || state_q == ST_HGT) ? step_q + 4'd1 : '0;
			if (acc_in) begin
				nslot_q  <= '0;
				is_cur_q <= 1'b1;
			end
			if (state_q == ST_EVAL) begin
				if (hit && !is_cur_q) begin
					cur_q <= tri_q;
				end else if (!hit && !is_cur_q) begin
					nslot_q <= nslot_q + 2'd1;
				end
			end
			if (state_q == ST_NCHK) begin
				if (nrd_q.valid && (32'(nrd_q.idx) < 32'(MAX_TRIANGLES))) begin
					is_cur_q <= 1'b0;
				end else begin
					nslot_q <= nslot_q + 2'd1;
				end
			end
		end
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_q     <= req.coord_x;
			py_q     <= req.coord_y;
			tri_q    <= cur_q;
			res_hv_q <= 1'b0;
			res_h_q  <= '0;
		end
		if (state_q == ST_NCHK) begin
			tri_q <= nrd_q.idx;
		end
		if (state_q == ST_VRD && rcnt_q != 2'd0) begin
			crn_q[rcnt_q - 2'd1] <= vrd_q;
		end
		if (state_q == ST_BARY) begin
			case (step_q)
				4'd3: det_q <= acc[WW-1:0];
				4'd5: w0_q  <= acc[WW-1:0];
				4'd7: w1_q  <= acc[WW-1:0];
				4'd9: w2_q  <= acc[WW-1:0];
				default: ;
			endcase
		end
		if (state_q == ST_NORM && det_q[WW-1]) begin
			det_q <= -det_q;
			w0_q  <= -w0_q;
			w1_q  <= -w1_q;
			w2_q  <= -w2_q;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			res_hv_q <= 1'b1;
			res_h_q  <= hsat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!resp_valid_q || resp.ready)) begin
			resp_valid_q <= 1'b1;
		end else if (resp.ready) begin
			resp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!resp_valid_q || resp.ready)) begin
			resp_hv_q  <= res_hv_q;
			resp_h_q   <= res_h_q;
			resp_cur_q <= cur_q;
		end
	end

	assign resp.valid         = resp_valid_q;
	assign resp.height_valid  = resp_hv_q;
	assign resp.height        = resp_h_q;
	assign resp.current_index = resp_cur_q;

	`include "mesh_height_tracker_assert.svh"

	`MHT_ASSERT_NOW(a_miss_zero, resp.valid && !resp.height_valid, resp.height == '0, "miss beat carries a height")
	`MHT_ASSERT_NEXT(a_out_from_out, state_q != ST_OUT && !resp.valid, !resp.valid, "result beat without output state")
	`MHT_ASSERT_NEXT(a_cur_move, state_q != ST_EVAL, $stable(cur_q), "current triangle moved outside evaluation")
	`MHT_ASSERT_NOW(a_div_done, div_stat.done, state_q == ST_DIV, "divider finished outside height step")
endmodule

### src/mht_mac.sv
module mht_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mht_pkg::mac_ctrl_t               ctrl,
	input  logic signed [mht_pkg::MW-1:0]    op_a,
	input  logic signed [mht_pkg::MW-1:0]    op_b,
	output logic signed [mht_pkg::ACCW-1:0]  acc
);
	import mht_pkg::*;

	logic signed [PW-1:0]   prod_s1;
	mac_ctrl_t              ctrl_s1;
	logic signed [ACCW-1:0] acc_q;
	logic signed [ACCW-1:0] base;
	logic signed [ACCW-1:0] term;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// accumulate stage, high partial products weighted by the low-half width
	always_comb begin
		base = ctrl_s1.clr ? '0 : acc_q;
		term = {{(ACCW-PW){prod_s1[PW-1]}}, prod_s1};
		if (ctrl_s1.hi) begin
			term = term <<< LOW_W;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.en) begin
			acc_q <= ctrl_s1.sub ? base - term : base + term;
		end
	end

	assign acc = acc_q;
endmodule

### src/mht_div.sv
module mht_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [mht_pkg::ACCW-1:0] num,
	input  logic [mht_pkg::WW-1:0]          den,
	output mht_pkg::div_stat_t              stat,
	output logic signed [mht_pkg::QW:0]     quot
);
	import mht_pkg::*;

	logic [ACCW-1:0] rem_q;
	logic [ACCW-1:0] dsh_q;
	logic [QW-1:0]   q_q;
	logic            neg_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            fit;

	assign fit = rem_q >= dsh_q;

	// sequencing of the restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, magnitude only
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ACCW-1];
			rem_q <= num[ACCW-1] ? ACCW'(-num) : ACCW'(num);
			dsh_q <= ACCW'(den) << (QW - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= {q_q[QW-2:0], fit};
			dsh_q <= dsh_q >> 1;
		end
	end

	// quotient rounded toward zero
	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	assign stat = '{busy: busy_q, done: done_q};
endmodule
